// ===== sv/nfa_pkg.sv =====
// ----------------------------------------------------------------------------
// nfa_pkg
// shared types and constants of the neighbour fork arbiter
// ----------------------------------------------------------------------------
package nfa_pkg;

	localparam int SEATS_DEF = 7;
	localparam int SEAT_W = 3;
	localparam int MASK_W = 7;
	localparam logic [MASK_W-1:0] HANDOFF_RESET = 7'd74;
	// output queue depth, power of two
	localparam int RES_DEPTH = 4;

	localparam logic MODE_REQUEST = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		PH_THINK  = 2'd0,
		PH_HUNGRY = 2'd1,
		PH_EAT    = 2'd2
	} phase_t;

	// what a cell shows its two ring neighbours
	typedef struct packed {
		phase_t phase;
		logic   handed;
		logic   grant_l;
	} nb_t;

	// role of a seat in the current transaction, also used for grant flags
	typedef struct packed {
		logic s;
		logic l;
		logic r;
	} seat_role_t;

	typedef struct packed {
		logic [SEAT_W-1:0] granted_seat;
		logic              last_grant;
	} res_t;

endpackage

// ===== sv/nfa_if.sv =====
// ----------------------------------------------------------------------------
// nfa_ev_if / nfa_res_if
// valid/ready channels for events in and grants out
// ----------------------------------------------------------------------------
interface nfa_ev_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [2:0] seat;

	modport source (output valid, output mode, output seat, input ready);
	modport sink (input valid, input mode, input seat, output ready);
endinterface

interface nfa_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] granted_seat;
	logic       last_grant;

	modport source (output valid, output granted_seat, output last_grant, input ready);
	modport sink (input valid, input granted_seat, input last_grant, output ready);
endinterface

// ===== sv/nfa_cell.sv =====
// ----------------------------------------------------------------------------
// nfa_cell
// one seat of the ring: its phase and the token of the fork to its right
// ----------------------------------------------------------------------------
module nfa_cell #(
	parameter logic INIT_HANDED = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_load,
	input  logic                cfg_handed,
	input  logic                ev_acc,
	input  logic                ev_mode,
	input  nfa_pkg::seat_role_t role,
	input  nfa_pkg::nb_t        left_nb,
	input  nfa_pkg::nb_t        right_nb,
	output nfa_pkg::nb_t        nb,
	output nfa_pkg::seat_role_t grant
);
	import nfa_pkg::*;

	phase_t phase_q;
	logic   handed_q;   // fork owned by the right neighbour
	logic   req;
	logic   rel_own;
	logic   rel_right;
	logic   rel_left;

	always_comb begin
		req       = ev_acc && role.s && (ev_mode == MODE_REQUEST) && (phase_q == PH_THINK);
		rel_own   = ev_acc && role.s && (ev_mode == MODE_RELEASE) && (phase_q == PH_EAT);
		// right neighbour is the releasing seat
		rel_right = ev_acc && role.l && (ev_mode == MODE_RELEASE) && (right_nb.phase == PH_EAT);
		// left neighbour is the releasing seat
		rel_left  = ev_acc && role.r && (ev_mode == MODE_RELEASE) && (left_nb.phase == PH_EAT);

		grant.s = req && (left_nb.phase != PH_EAT) && (right_nb.phase != PH_EAT)
			&& !handed_q && left_nb.handed;
		grant.l = rel_right && (phase_q == PH_HUNGRY) && (left_nb.phase != PH_EAT)
			&& left_nb.handed;
		// in a ring of three the right neighbour may have just been granted
		grant.r = rel_left && (phase_q == PH_HUNGRY) && (right_nb.phase != PH_EAT)
			&& !right_nb.grant_l && !handed_q;

		nb = '{phase: phase_q, handed: handed_q, grant_l: grant.l};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_THINK;
			handed_q <= INIT_HANDED;
		end else if (cfg_load) begin
			phase_q  <= PH_THINK;
			handed_q <= cfg_handed;
		end else if (req) begin
			phase_q <= grant.s ? PH_EAT : PH_HUNGRY;
		end else if (rel_own) begin
			phase_q  <= PH_THINK;
			handed_q <= 1'b1;
		end else if (rel_right) begin
			handed_q <= 1'b0;
			if (grant.l) begin
				phase_q <= PH_EAT;
			end
		end else if (grant.r) begin
			phase_q <= PH_EAT;
		end
	end

`ifndef SYNTHESIS
	a_no_adjacent_eat: assert property (@(posedge clk) disable iff (!arst_n)
		!(phase_q == PH_EAT && right_nb.phase == PH_EAT))
		else $error("two neighbouring seats eating");

	a_eat_holds_forks: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EAT) |-> (!handed_q && left_nb.handed))
		else $error("eating seat does not own both forks");
`endif

endmodule

// ===== sv/nfa_res_fifo.sv =====
// ----------------------------------------------------------------------------
// nfa_res_fifo
// grant queue, takes up to two entries and gives one per cycle while out_ready is high
// ----------------------------------------------------------------------------
module nfa_res_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      push_n,
	input  nfa_pkg::res_t   e0,
	input  nfa_pkg::res_t   e1,
	output logic            room2,
	output logic            out_valid,
	input  logic            out_ready,
	output nfa_pkg::res_t   head
);
	import nfa_pkg::*;

	localparam int PW = $clog2(RES_DEPTH);
	localparam int CW = $clog2(RES_DEPTH + 1);

	res_t          mem_q [RES_DEPTH];
	logic [PW-1:0] rd_q;
	logic [PW-1:0] wr_q;
	logic [CW-1:0] cnt_q;
	logic          pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_q];
	assign room2     = (cnt_q <= CW'(RES_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= e0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_q + PW'(1)] <= e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push_n);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule

// ===== sv/neighbor_fork_arbiter_top.sv =====
// a grant is written into the grant queue with its event and offered from the queue head
// throughput: one event per cycle while ev.ready is high; one grant leaves per cycle
// while res.ready is high, so a release granting both neighbours queues two grants
// input ready drops while fewer than two slots of the four-entry grant queue are free
// reset: every seat thinking, fork tokens loaded from handoff mask 74
// a write to the mask reloads the tokens and returns every seat to thinking
// ----------------------------------------------------------------------------
// neighbor_fork_arbiter_top
// ring of seat cells sharing fork tokens, with a queue of grants
// ----------------------------------------------------------------------------
module neighbor_fork_arbiter_top #(
	parameter int SEATS = nfa_pkg::SEATS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	nfa_ev_if.sink                     ev,
	nfa_res_if.source                  res,
	input  logic                       cfg_we,
	input  logic [nfa_pkg::MASK_W-1:0] cfg_wdata
);
	import nfa_pkg::*;

	localparam int SW = $clog2(SEATS + 1);
	localparam int IW = (SW > SEAT_W) ? SW : SEAT_W;
	localparam logic [SEATS-1:0] INIT_V = SEATS'(HANDOFF_RESET);

	logic             accept;
	logic             s_ok;
	logic [IW-1:0]    s_idx;
	logic [IW-1:0]    l_idx;
	logic [IW-1:0]    r_idx;
	logic [SEATS-1:0] sel_s;
	logic [SEATS-1:0] sel_l;
	logic [SEATS-1:0] sel_r;
	logic [SEATS-1:0] cfg_v;
	logic [SEATS-1:0] gs_v;
	logic [SEATS-1:0] gl_v;
	logic [SEATS-1:0] gr_v;
	logic             gs_any;
	logic             gl_any;
	logic             gr_any;
	logic [1:0]       push_n;
	logic             room2;
	res_t             e0;
	res_t             e1;
	res_t             head;
	nb_t              nb [SEATS];

	assign accept = ev.valid && ev.ready;
	assign ev.ready = room2;

	always_comb begin
		s_idx = IW'(ev.seat);
		s_ok  = (s_idx < IW'(SEATS));
		l_idx = (s_idx == '0) ? IW'(SEATS - 1) : s_idx - IW'(1);
		r_idx = (s_idx == IW'(SEATS - 1)) ? '0 : s_idx + IW'(1);
		sel_s = s_ok ? (SEATS'(1) << ev.seat) : '0;
		sel_l = {sel_s[0], sel_s[SEATS-1:1]};
		sel_r = {sel_s[SEATS-2:0], sel_s[SEATS-1]};
		cfg_v = SEATS'(cfg_wdata);
	end

	for (genvar i = 0; i < SEATS; i++) begin : g_cell
		seat_role_t role;
		seat_role_t gnt;

		assign role = '{s: sel_s[i], l: sel_l[i], r: sel_r[i]};

		nfa_cell #(
			.INIT_HANDED (INIT_V[i])
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cfg_load   (cfg_we),
			.cfg_handed (cfg_v[i]),
			.ev_acc     (accept),
			.ev_mode    (ev.mode),
			.role       (role),
			.left_nb    (nb[(i + SEATS - 1) % SEATS]),
			.right_nb   (nb[(i + 1) % SEATS]),
			.nb         (nb[i]),
			.grant      (gnt)
		);

		assign gs_v[i] = gnt.s;
		assign gl_v[i] = gnt.l;
		assign gr_v[i] = gnt.r;
	end

	// left neighbour's grant goes out first
	always_comb begin
		gs_any = |gs_v;
		gl_any = |gl_v;
		gr_any = |gr_v;
		if (gs_any) begin
			push_n = 2'd1;
		end else begin
			push_n = {1'b0, gl_any} + {1'b0, gr_any};
		end
		e0.granted_seat = gs_any ? s_idx[SEAT_W-1:0] :
			(gl_any ? l_idx[SEAT_W-1:0] : r_idx[SEAT_W-1:0]);
		e0.last_grant   = !(gl_any && gr_any);
		e1.granted_seat = r_idx[SEAT_W-1:0];
		e1.last_grant   = 1'b1;
	end

	nfa_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.e0        (e0),
		.e1        (e1),
		.room2     (room2),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.head      (head)
	);

	assign res.granted_seat = head.granted_seat;
	assign res.last_grant   = head.last_grant;

`ifndef SYNTHESIS
	a_two_only_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && push_n == 2'd2) |-> (ev.mode == MODE_RELEASE))
		else $error("two grants from a request transaction");

	a_single_role_grant: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(gs_v) && $onehot0(gl_v) && $onehot0(gr_v))
		else $error("more than one cell granted in one role");

	a_bad_seat_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !s_ok) |-> (push_n == 2'd0))
		else $error("grant from out of range seat");
`endif

endmodule
